/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL; they compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VCPI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define VCPI_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define VCPI_ASSERT(name, prop, msg)
`define VCPI_ASSERT_NEVER(name, expr, msg)
`endif
`endif

/* rtl/vcpi_pkg.sv */
// Shared types and constants of the display card port interface.
`timescale 1ns / 1ps
package vcpi_pkg;

  localparam int unsigned CtrlRegCount = 16;
  localparam int unsigned CtrlRegDepth = 16;
  localparam int unsigned ScreenDepth  = 2048;
  localparam int unsigned ScreenAw     = $clog2(ScreenDepth);

  // Port codes (low nibble of the I/O address).
  localparam logic [3:0] PortAddrLow  = 4'h0;
  localparam logic [3:0] PortAddrHigh = 4'h1;
  localparam logic [3:0] PortChar     = 4'h2;
  localparam logic [3:0] PortAttr     = 4'h3;
  localparam logic [3:0] PortCtrlIdx  = 4'h8;
  localparam logic [3:0] PortCtrlData = 4'h9;

  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  localparam logic [7:0] ByteIdle = 8'hFF;

  typedef enum logic [1:0] {
    SelImm,
    SelChar,
    SelAttr
  } vcpi_sel_e;

  typedef struct packed {
    logic                rd_en;
    logic                wr_char;
    logic                wr_attr;
    logic [ScreenAw-1:0] addr;
    logic [7:0]          char_data;
    logic [7:0]          attr_data;
  } vcpi_mem_req_t;

  typedef struct packed {
    vcpi_sel_e  sel;
    logic [7:0] imm;
  } vcpi_rsp_t;

endpackage

/* rtl/video_card_port_interface.sv */
// Top level of the text display card I/O port interface.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+----------------------------
//   in      | sink      | in_valid_i / in_stall_o   | op_i, port_i, write_data_i
//   out     | source    | out_valid_o / out_stall_i | read_data_o
//
// One beat per cycle sustained while out_stall_i is low and no sweep runs. A
// beat goes through a read stage (screen memory read, registered data) and then
// the output register: s1_valid_q, then out_valid_q, which drives out_valid_o.
// All state updates land at the accept edge, so the next beat always sees them.
// After reset a clearing sweep zeroes both screen memories, with in_stall_o
// high. A stalled output holds the read stage; input then stalls.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module video_card_port_interface (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       op_i,
  input  logic [3:0] port_i,
  input  logic [7:0] write_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o
);
  import vcpi_pkg::*;

  vcpi_mem_req_t mem_req;
  vcpi_rsp_t     rsp;
  logic          mem_busy;
  logic [7:0]    char_rd, attr_rd;

  logic       in_accept;
  logic       s1_adv;
  logic       s1_valid_q, s1_valid_d;
  vcpi_sel_e  s1_sel_q;
  logic [7:0] s1_imm_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] read_data_q;
  logic [7:0] s1_value;

  // Read stage moves on when the output register is empty or being drained.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = mem_busy || (s1_valid_q && !s1_adv);
  assign in_accept  = in_valid_i && !in_stall_o;

  vcpi_port_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .op_i         (op_i),
    .port_i       (port_i),
    .write_data_i (write_data_i),
    .mem_req_o    (mem_req),
    .rsp_o        (rsp)
  );

  vcpi_screen_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .busy_o    (mem_busy),
    .char_rd_o (char_rd),
    .attr_rd_o (attr_rd)
  );

  always_comb begin
    case (s1_sel_q)
      SelChar: s1_value = char_rd;
      SelAttr: s1_value = attr_rd;
      default: s1_value = s1_imm_q;
    endcase
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_sel_q <= rsp.sel;
      s1_imm_q <= rsp.imm;
    end
    if (s1_adv) begin
      read_data_q <= s1_value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

  // No beat may enter while the clearing sweep owns the memories.
  `VCPI_ASSERT_NEVER(a_no_accept_in_clear, mem_busy && in_accept, "beat accepted during clear")
  // A full read stage behind a stalled output must block the input.
  `VCPI_ASSERT(a_stall_backpressure,
               (s1_valid_q && out_valid_q && out_stall_i) |-> in_stall_o,
               "read stage overrun")
  // A write beat always yields a zero immediate result.
  `VCPI_ASSERT(a_write_result_zero,
               (in_accept && op_i == OpWrite) |=> (s1_sel_q == SelImm && s1_imm_q == 8'h00),
               "write result not zero")

endmodule

/* rtl/vcpi_screen_mem.sv */
// Character and attribute screen memories with the post-reset clearing sweep.
`timescale 1ns / 1ps
module vcpi_screen_mem (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  vcpi_pkg::vcpi_mem_req_t req_i,
  output logic                   busy_o,
  output logic [7:0]             char_rd_o,
  output logic [7:0]             attr_rd_o
);
  import vcpi_pkg::*;

  logic [7:0] char_mem [ScreenDepth];
  logic [7:0] attr_mem [ScreenDepth];

  logic                clr_busy_q, clr_busy_d;
  logic [ScreenAw-1:0] clr_cnt_q, clr_cnt_d;
  logic [7:0]          char_rd_q, attr_rd_q;

  logic                wr_char, wr_attr;
  logic [ScreenAw-1:0] wr_addr;
  logic [7:0]          wr_char_data, wr_attr_data;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == ScreenAw'(ScreenDepth - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  // Sweep owns the write port until it is done.
  always_comb begin
    if (clr_busy_q) begin
      wr_char      = 1'b1;
      wr_attr      = 1'b1;
      wr_addr      = clr_cnt_q;
      wr_char_data = '0;
      wr_attr_data = '0;
    end else begin
      wr_char      = req_i.wr_char;
      wr_attr      = req_i.wr_attr;
      wr_addr      = req_i.addr;
      wr_char_data = req_i.char_data;
      wr_attr_data = req_i.attr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_char) begin
      char_mem[wr_addr] <= wr_char_data;
    end
    if (wr_attr) begin
      attr_mem[wr_addr] <= wr_attr_data;
    end
    if (req_i.rd_en) begin
      char_rd_q <= char_mem[req_i.addr];
      attr_rd_q <= attr_mem[req_i.addr];
    end
  end

  assign busy_o    = clr_busy_q;
  assign char_rd_o = char_rd_q;
  assign attr_rd_o = attr_rd_q;

endmodule

/* rtl/vcpi_port_regs.sv */
// Port decode, latch registers and display-controller register file.
`timescale 1ns / 1ps
module vcpi_port_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic                    op_i,
  input  logic [3:0]              port_i,
  input  logic [7:0]              write_data_i,
  output vcpi_pkg::vcpi_mem_req_t mem_req_o,
  output vcpi_pkg::vcpi_rsp_t     rsp_o
);
  import vcpi_pkg::*;

  logic [7:0] addr_low_q, addr_high_q, char_latch_q, attr_latch_q;
  logic [4:0] ctrl_idx_q;
  logic [7:0] ctrl_regs_q [CtrlRegDepth];

  logic is_wr;
  logic ctrl_wr_ok;

  assign is_wr      = accept_i && (op_i == OpWrite);
  assign ctrl_wr_ok = (ctrl_idx_q < 5'(CtrlRegCount));

  always_comb begin
    mem_req_o           = '0;
    mem_req_o.addr      = {addr_high_q[2:0], addr_low_q};
    mem_req_o.char_data = char_latch_q;
    mem_req_o.attr_data = attr_latch_q;
    rsp_o.sel           = SelImm;
    rsp_o.imm           = '0;
    if (op_i == OpWrite) begin
      if (port_i == PortAddrLow) begin
        // Store uses the new low byte.
        mem_req_o.addr = {addr_high_q[2:0], write_data_i};
        if (addr_high_q[7]) begin
          mem_req_o.wr_char = accept_i && addr_high_q[6];
          mem_req_o.wr_attr = accept_i && addr_high_q[5];
        end
      end
    end else begin
      case (port_i)
        PortChar: begin
          if (addr_high_q[7]) begin
            rsp_o.imm = ByteIdle;
          end else begin
            rsp_o.sel       = SelChar;
            mem_req_o.rd_en = accept_i;
          end
        end
        PortAttr: begin
          if (addr_high_q[7]) begin
            rsp_o.imm = ByteIdle;
          end else begin
            rsp_o.sel       = SelAttr;
            mem_req_o.rd_en = accept_i;
          end
        end
        PortCtrlIdx:  rsp_o.imm = {3'b000, ctrl_idx_q};
        PortCtrlData: rsp_o.imm = ctrl_regs_q[ctrl_idx_q[3:0]];
        default:      rsp_o.imm = ByteIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_low_q   <= '0;
      addr_high_q  <= '0;
      char_latch_q <= '0;
      attr_latch_q <= '0;
      ctrl_idx_q   <= '0;
      for (int i = 0; i < CtrlRegDepth; i++) begin
        ctrl_regs_q[i] <= '0;
      end
    end else if (is_wr) begin
      case (port_i)
        PortAddrLow:  addr_low_q   <= write_data_i;
        PortAddrHigh: addr_high_q  <= write_data_i;
        PortChar:     char_latch_q <= write_data_i;
        PortAttr:     attr_latch_q <= write_data_i;
        PortCtrlIdx:  ctrl_idx_q   <= write_data_i[4:0];
        PortCtrlData: begin
          if (ctrl_wr_ok) begin
            ctrl_regs_q[ctrl_idx_q[3:0]] <= write_data_i;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* tb/sv/video_card_port_interface_test.sv */
// Self-checking testbench for the display card I/O port interface.
`timescale 1ns / 1ps
module video_card_port_interface_test;
  import vcpi_pkg::*;

  localparam int unsigned CycleLimit    = 200000;  // clearing sweep plus slow traffic, many times over
  localparam int unsigned IdlePct       = 31;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned MaxReports    = 100;

  // Bits of the address-high byte that steer a store on a port 0 write.
  localparam logic [7:0] StoreEnBit = 8'h80;
  localparam logic [7:0] CharEnBit  = 8'h40;
  localparam logic [7:0] AttrEnBit  = 8'h20;
  localparam logic [4:0] IdxMask    = 5'h1F;

  // Ports with no function, used for the unmapped cases.
  localparam logic [3:0] PortGap   = 4'h4;
  localparam logic [3:0] PortSpare = 4'hF;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       op_i;
  logic [3:0] port_i;
  logic [7:0] write_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] read_data_o;

  video_card_port_interface dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .port_i       (port_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the card state, updated at each accepted beat.
  logic [7:0]          addr_lo_q;
  logic [7:0]          addr_hi_q;
  logic [7:0]          char_q;
  logic [7:0]          attr_q;
  logic [4:0]          idx_q;
  logic [7:0]          ctrl_q   [CtrlRegDepth];
  logic [7:0]          char_scr [ScreenDepth];
  logic [7:0]          attr_scr [ScreenDepth];

  logic [7:0]          read_data_q [$];  // bytes still owed on the out channel
  int unsigned         n_sent;
  int unsigned         n_errors;
  int unsigned         n_cycles;
  bit                  idle_on;         // both sides idle at random while set

  function automatic logic [ScreenAw-1:0] screen_addr();
    return {addr_hi_q[2:0], addr_lo_q};
  endfunction

  // Applies one access to the shadow state and returns the byte the card owes.
  function automatic logic [7:0] predict_access(logic op, logic [3:0] port, logic [7:0] data);
    logic [7:0] rd;
    rd = 8'h00;
    if (op == OpWrite) begin
      case (port)
        PortAddrLow: begin
          addr_lo_q = data;
          // store only with the write bit armed; address bits 3 and 4 drop out
          if ((addr_hi_q & StoreEnBit) != 0) begin
            if ((addr_hi_q & CharEnBit) != 0) char_scr[screen_addr()] = char_q;
            if ((addr_hi_q & AttrEnBit) != 0) attr_scr[screen_addr()] = attr_q;
          end
        end
        PortAddrHigh: addr_hi_q = data;
        PortChar:     char_q = data;
        PortAttr:     attr_q = data;
        PortCtrlIdx:  idx_q = data[4:0] & IdxMask;
        PortCtrlData: if (idx_q < CtrlRegCount) ctrl_q[idx_q[3:0]] = data;
        default: ;  // unmapped write leaves everything alone
      endcase
    end else begin
      case (port)
        PortChar:     rd = ((addr_hi_q & StoreEnBit) != 0) ? ByteIdle : char_scr[screen_addr()];
        PortAttr:     rd = ((addr_hi_q & StoreEnBit) != 0) ? ByteIdle : attr_scr[screen_addr()];
        PortCtrlIdx:  rd = {3'b000, idx_q};
        PortCtrlData: rd = ctrl_q[idx_q[3:0]];  // index wraps to four bits on reads
        default:      rd = ByteIdle;
      endcase
    end
    return rd;
  endfunction

  // Presents one beat, waits for the handshake, then books the expected byte.
  // Valid is only lowered for an idle gap, so it never toggles within a step.
  task automatic send_access(input logic op, input logic [3:0] port, input logic [7:0] data);
    if (idle_on) begin
      while ($urandom_range(99) < IdlePct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    port_i       <= port;
    write_data_i <= data;
    // in_stall_o read right after the edge is its value at the edge
    do @(posedge clk_i); while (in_stall_o);
    read_data_q.push_back(predict_access(op, port, data));
    n_sent++;
  endtask

  // Receiver side: random stall, off during the no-idle stretch.
  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < IdlePct);
  end

  // Compares each returned beat with the oldest booked byte.
  always @(posedge clk_i) begin : check_read_data
    logic [7:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (read_data_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MaxReports)
          $display("%0t: read_data with nothing outstanding: expected none, actual %02h",
                   $time, read_data_o);
      end else begin
        want = read_data_q.pop_front();
        if (read_data_o !== want) begin
          n_errors++;
          if (n_errors <= MaxReports)
            $display("%0t: read_data mismatch: expected %02h, actual %02h",
                     $time, want, read_data_o);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CycleLimit) begin
      $display("video_card_port_interface_test: errors");
      $finish;
    end
  end

  // Everything reads back as zero or 0xFF straight out of reset.
  task automatic test_reset_values();
    send_access(OpRead, PortChar, 8'h00);
    send_access(OpRead, PortAttr, 8'hFF);
    send_access(OpRead, PortCtrlIdx, 8'h00);
    send_access(OpRead, PortCtrlData, 8'h00);
    send_access(OpRead, PortAddrLow, 8'h00);
  endtask

  // Stores through the armed address, top and bottom of the screen.
  task automatic test_screen_store();
    send_access(OpWrite, PortChar, 8'hFF);
    send_access(OpWrite, PortAttr, 8'hA5);
    send_access(OpWrite, PortAddrHigh, 8'hFF);  // armed, both lanes, bits 3/4 set
    send_access(OpWrite, PortAddrLow, 8'hFF);   // stores at the last cell
    send_access(OpRead, PortChar, 8'h00);       // armed: reads 0xFF
    send_access(OpWrite, PortAddrHigh, 8'h07);
    send_access(OpRead, PortChar, 8'h00);
    send_access(OpRead, PortAttr, 8'h00);
    send_access(OpWrite, PortChar, 8'h00);
    send_access(OpWrite, PortAddrHigh, StoreEnBit | CharEnBit);  // char lane only
    send_access(OpWrite, PortAddrLow, 8'h00);
    send_access(OpWrite, PortAddrHigh, 8'h00);
    send_access(OpRead, PortChar, 8'h00);
  endtask

  // Index above the register count: write dropped, read wraps.
  task automatic test_ctrl_index();
    send_access(OpWrite, PortCtrlIdx, 8'hFF);
    send_access(OpWrite, PortCtrlData, 8'h5A);
    send_access(OpRead, PortCtrlIdx, 8'h00);
    send_access(OpRead, PortCtrlData, 8'h00);
    send_access(OpWrite, PortCtrlIdx, 8'h0F);
    send_access(OpWrite, PortCtrlData, 8'hFF);
    send_access(OpRead, PortCtrlData, 8'h00);
  endtask

  task automatic test_unmapped_ports();
    send_access(OpWrite, PortSpare, 8'hFF);
    send_access(OpRead, PortSpare, 8'h00);
    send_access(OpRead, PortGap, 8'h00);
  endtask

  // Mostly well-formed store/readback and register sequences, some raw noise.
  task automatic test_random_traffic(input int unsigned n_items, input bit idle);
    int unsigned target;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [4:0]  idx;
    idle_on = idle;
    target  = n_sent + n_items;
    while (n_sent < target) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          hi = 8'($urandom);
          // a narrow low byte so stores land on the same cells again
          lo = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
          send_access(OpWrite, PortChar, 8'($urandom));
          send_access(OpWrite, PortAttr, 8'($urandom));
          send_access(OpWrite, PortAddrHigh, hi | StoreEnBit);
          send_access(OpWrite, PortAddrLow, lo);
          if ($urandom_range(1) == 1) begin
            send_access(OpWrite, PortAddrHigh, hi & ~StoreEnBit);
            send_access(OpWrite, PortAddrLow, lo);
            send_access(OpRead, PortChar, 8'($urandom));
            send_access(OpRead, PortAttr, 8'($urandom));
          end
        end
        5, 6, 7: begin
          idx = 5'($urandom);
          send_access(OpWrite, PortCtrlIdx, {3'($urandom), idx});
          send_access(OpWrite, PortCtrlData, 8'($urandom));
          send_access(OpRead, PortCtrlData, 8'($urandom));
          send_access(OpRead, PortCtrlIdx, 8'($urandom));
        end
        default: send_access(1'($urandom), 4'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    op_i         = OpRead;
    port_i       = PortAddrLow;
    write_data_i = 8'h00;
    out_stall_i  = 1'b0;
    n_sent       = 0;
    n_errors     = 0;
    n_cycles     = 0;
    idle_on      = 1'b1;
    addr_lo_q    = 8'h00;
    addr_hi_q    = 8'h00;
    char_q       = 8'h00;
    attr_q       = 8'h00;
    idx_q        = 5'h00;
    foreach (ctrl_q[i]) ctrl_q[i] = 8'h00;
    foreach (char_scr[i]) char_scr[i] = 8'h00;
    foreach (attr_scr[i]) attr_scr[i] = 8'h00;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the clearing sweep shows up as in_stall_o, send_access waits it out

    test_reset_values();
    test_screen_store();
    test_ctrl_index();
    test_unmapped_ports();
    test_random_traffic(600, 1'b1);
    test_random_traffic(300, 1'b0);  // back-to-back beats, no stalls
    test_random_traffic(600, 1'b1);

    in_valid_i <= 1'b0;
    while (read_data_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("video_card_port_interface_test: clean");
    end else begin
      $display("video_card_port_interface_test: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/vcpi_pkg.sv
rtl/vcpi_screen_mem.sv
rtl/vcpi_port_regs.sv
rtl/video_card_port_interface.sv
tb/sv/video_card_port_interface_test.sv
